FILE: rtl/sed_pkg.sv
// ---------------------------------------------------------------------------
// sed_pkg
// Widths, register codes and step functions for the symmetric epipolar
// distance pipeline.
// ---------------------------------------------------------------------------
package sed_pkg;

  localparam int COORD_BITS     = 12;
  localparam int COEF_BITS      = 32;
  localparam int DIST_FRAC_BITS = 8;

  localparam int PIX_W  = 12;
  localparam int DIST_W = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // line coefficients and their magnitudes
  localparam int PROD_W = COEF_BITS + COORD_BITS + 1;
  localparam int LINE_W = PROD_W + 1;
  localparam int LMAG_W = LINE_W - 1;
  localparam int LLO    = (LMAG_W + 1) / 2;
  localparam int LHI    = LMAG_W - LLO;
  localparam int NORM_W = 2 * LMAG_W + 1;

  // epipolar residual and its scaled square
  localparam int RES_W  = LINE_W + COORD_BITS + 1;
  localparam int RMAG_W = RES_W - 1;
  localparam int RLO    = (RMAG_W + 1) / 2;
  localparam int RHI    = RMAG_W - RLO;
  localparam int RSQ_W  = 2 * RMAG_W + 2 * DIST_FRAC_BITS;

  // quotient bits and root remainder
  localparam int QBITS  = 2 * DIST_W;
  localparam int SREM_W = DIST_W + 3;

  // configuration port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam logic [2:0] REG_F11_12 = 3'd0;
  localparam logic [2:0] REG_F13_21 = 3'd1;
  localparam logic [2:0] REG_F22_23 = 3'd2;
  localparam logic [2:0] REG_F31_32 = 3'd3;
  localparam logic [2:0] REG_F33    = 3'd4;

  typedef struct packed {
    logic [NORM_W-1:0] n_l;
    logic [NORM_W-1:0] n_r;
    logic [NORM_W-1:0] rem_l;
    logic [NORM_W-1:0] rem_r;
    logic [QBITS-1:0]  q_l;
    logic [QBITS-1:0]  q_r;
    logic [QBITS-1:0]  r_low;
    logic              sat_l;
    logic              sat_r;
    logic              deg;
  } div_t;

  typedef struct packed {
    logic [QBITS-1:0]  q_l;
    logic [QBITS-1:0]  q_r;
    logic [SREM_W-1:0] rem_l;
    logic [SREM_W-1:0] rem_r;
    logic [DIST_W-1:0] root_l;
    logic [DIST_W-1:0] root_r;
    logic              sat_l;
    logic              sat_r;
    logic              deg;
  } sq_t;

  // low coefficient bits of a 32-bit half, two's complement
  function automatic logic signed [COEF_BITS-1:0] coef(input logic [31:0] half);
    return half[COEF_BITS-1:0];
  endfunction

  function automatic logic [LMAG_W-1:0] lmag(input logic signed [LINE_W-1:0] a);
    logic signed [LINE_W-1:0] t;
    t = a[LINE_W-1] ? -a : a;
    return t[LMAG_W-1:0];
  endfunction

  function automatic logic [RMAG_W-1:0] rmag(input logic signed [RES_W-1:0] a);
    logic signed [RES_W-1:0] t;
    t = a[RES_W-1] ? -a : a;
    return t[RMAG_W-1:0];
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [NORM_W:0] div_step(input logic [NORM_W-1:0] rem,
                                               input logic [NORM_W-1:0] n,
                                               input logic              nb);
    logic [NORM_W:0] t;
    logic [NORM_W:0] d;
    logic            ge;
    t  = {rem, nb};
    ge = t >= {1'b0, n};
    d  = t - {1'b0, n};
    return ge ? {1'b1, d[NORM_W-1:0]} : {1'b0, t[NORM_W-1:0]};
  endfunction

  // one square root digit: {new root, new remainder}
  function automatic logic [DIST_W+SREM_W-1:0] sqrt_step(input logic [SREM_W-1:0] rem,
                                                         input logic [DIST_W-1:0] root,
                                                         input logic [1:0]        nb);
    logic [SREM_W-1:0] t;
    logic [SREM_W-1:0] trial;
    logic              ge;
    t     = {rem[SREM_W-3:0], nb};
    trial = {{(SREM_W-DIST_W-2){1'b0}}, root, 2'b01};
    ge    = t >= trial;
    return {root[DIST_W-2:0], ge, (ge ? t - trial : t)};
  endfunction

endpackage

FILE: rtl/symmetric_epipolar_distance.sv
// ---------------------------------------------------------------------------
// symmetric_epipolar_distance
// Sum of both points' distances to the other point's epipolar line, Q16.8.
// ---------------------------------------------------------------------------
// Pipeline: the arithmetic stages, a divider entry stage, 48 divider stages,
// 24 root stages and the output register lie between an accepted start and done.
// Throughput: one pair per cycle; busy stays low, the divider and root
// pipelines each retire one digit per stage.
// Reset clears all valid bits and the matrix registers to zero; the zero
// matrix answers every pair as degenerate.
module symmetric_epipolar_distance
  import sed_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  left_x,
  input  logic [PIX_W-1:0]  left_y,
  input  logic [PIX_W-1:0]  right_x,
  input  logic [PIX_W-1:0]  right_y,
  output logic              done,
  output logic [DIST_W-1:0] distance,
  output logic              degenerate
);

  // configuration registers
  logic [63:0] f_11_12, f_13_21, f_22_23, f_31_32;
  logic [31:0] f_33;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_11_12 <= '0;
      f_13_21 <= '0;
      f_22_23 <= '0;
      f_31_32 <= '0;
      f_33    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_F11_12: f_11_12 <= pwdata;
        REG_F13_21: f_13_21 <= pwdata;
        REG_F22_23: f_22_23 <= pwdata;
        REG_F31_32: f_31_32 <= pwdata;
        REG_F33:    f_33    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_F11_12: prdata = f_11_12;
      REG_F13_21: prdata = f_13_21;
      REG_F22_23: prdata = f_22_23;
      REG_F31_32: prdata = f_31_32;
      REG_F33:    prdata = {32'd0, f_33};
      default:    prdata = '0;
    endcase
  end

  logic signed [COEF_BITS-1:0] c11, c12, c13, c21, c22, c23, c31, c32, c33;
  assign c11 = coef(f_11_12[31:0]);
  assign c12 = coef(f_11_12[63:32]);
  assign c13 = coef(f_13_21[31:0]);
  assign c21 = coef(f_13_21[63:32]);
  assign c22 = coef(f_22_23[31:0]);
  assign c23 = coef(f_22_23[63:32]);
  assign c31 = coef(f_31_32[31:0]);
  assign c32 = coef(f_31_32[63:32]);
  assign c33 = coef(f_33);

  logic signed [COORD_BITS:0] xl, yl, xr, yr;
  assign xl = {1'b0, left_x[COORD_BITS-1:0]};
  assign yl = {1'b0, left_y[COORD_BITS-1:0]};
  assign xr = {1'b0, right_x[COORD_BITS-1:0]};
  assign yr = {1'b0, right_y[COORD_BITS-1:0]};

  logic [6:1] v;

  // stage 1: coefficient by coordinate products
  logic signed [PROD_W-1:0] p1 [10];
  logic signed [COORD_BITS:0] xr1, yr1, xr2, yr2;

  always_ff @(posedge clk) begin
    p1[0] <= c11 * xl;
    p1[1] <= c12 * yl;
    p1[2] <= c21 * xl;
    p1[3] <= c22 * yl;
    p1[4] <= c31 * xl;
    p1[5] <= c32 * yl;
    p1[6] <= c11 * xr;
    p1[7] <= c21 * yr;
    p1[8] <= c12 * xr;
    p1[9] <= c22 * yr;
    xr1   <= xr;
    yr1   <= yr;
  end

  // stage 2: line coefficients
  logic signed [LINE_W-1:0] al2, bl2, cl2, ar2, br2;

  always_ff @(posedge clk) begin
    al2 <= p1[0] + p1[1] + c13;
    bl2 <= p1[2] + p1[3] + c23;
    cl2 <= p1[4] + p1[5] + c33;
    ar2 <= p1[6] + p1[7] + c31;
    br2 <= p1[8] + p1[9] + c32;
    xr2 <= xr1;
    yr2 <= yr1;
  end

  // stage 3: residual terms and partial squares of the four magnitudes
  logic [LMAG_W-1:0] m2 [4];
  assign m2[0] = lmag(al2);
  assign m2[1] = lmag(bl2);
  assign m2[2] = lmag(ar2);
  assign m2[3] = lmag(br2);

  logic [2*LHI-1:0]     hh3 [4];
  logic [LHI+LLO-1:0]   hl3 [4];
  logic [2*LLO-1:0]     ll3 [4];
  logic signed [RES_W-1:0]  rx3, ry3;
  logic signed [LINE_W-1:0] cl3;
  logic deg3;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      hh3[i] <= m2[i][LMAG_W-1:LLO] * m2[i][LMAG_W-1:LLO];
      hl3[i] <= m2[i][LMAG_W-1:LLO] * m2[i][LLO-1:0];
      ll3[i] <= m2[i][LLO-1:0] * m2[i][LLO-1:0];
    end
    rx3  <= al2 * xr2;
    ry3  <= bl2 * yr2;
    cl3  <= cl2;
    deg3 <= (al2 == '0 && bl2 == '0) || (ar2 == '0 && br2 == '0);
  end

  // stage 4: residual and full squares
  logic signed [RES_W-1:0] r4;
  logic [NORM_W-1:0] sq4 [4];
  logic deg4;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq4[i] <= (NORM_W'(hh3[i]) << (2 * LLO)) + (NORM_W'(hl3[i]) << (LLO + 1))
                + NORM_W'(ll3[i]);
    end
    r4   <= rx3 + ry3 + cl3;
    deg4 <= deg3;
  end

  // stage 5: line norms and partial squares of the residual
  logic [RMAG_W-1:0] rm4;
  assign rm4 = rmag(r4);

  logic [2*RHI-1:0]   rhh5;
  logic [RHI+RLO-1:0] rhl5;
  logic [2*RLO-1:0]   rll5;
  logic [NORM_W-1:0]  nl5, nr5, nl6, nr6;
  logic deg5, deg6;

  always_ff @(posedge clk) begin
    rhh5 <= rm4[RMAG_W-1:RLO] * rm4[RMAG_W-1:RLO];
    rhl5 <= rm4[RMAG_W-1:RLO] * rm4[RLO-1:0];
    rll5 <= rm4[RLO-1:0] * rm4[RLO-1:0];
    nl5  <= sq4[0] + sq4[1];
    nr5  <= sq4[2] + sq4[3];
    deg5 <= deg4;
  end

  // stage 6: scaled squared residual
  logic [RSQ_W-1:0] rsq6;

  always_ff @(posedge clk) begin
    rsq6 <= ((RSQ_W'(rhh5) << (2 * RLO)) + (RSQ_W'(rhl5) << (RLO + 1)) + RSQ_W'(rll5))
            << (2 * DIST_FRAC_BITS);
    nl6  <= nl5;
    nr6  <= nr5;
    deg6 <= deg5;
  end

  // divider: entry stage checks for overflow, then one quotient bit per stage
  logic [RSQ_W-1:0] rtop6;
  assign rtop6 = rsq6 >> QBITS;

  div_t div_pipe [QBITS+1];
  logic [QBITS:0] div_v;

  always_ff @(posedge clk) begin
    div_pipe[0].n_l   <= nl6;
    div_pipe[0].n_r   <= nr6;
    div_pipe[0].rem_l <= NORM_W'(rtop6);
    div_pipe[0].rem_r <= NORM_W'(rtop6);
    div_pipe[0].q_l   <= '0;
    div_pipe[0].q_r   <= '0;
    div_pipe[0].r_low <= rsq6[QBITS-1:0];
    div_pipe[0].sat_l <= rtop6 >= RSQ_W'(nl6);
    div_pipe[0].sat_r <= rtop6 >= RSQ_W'(nr6);
    div_pipe[0].deg   <= deg6;
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_div
    logic [NORM_W:0] sl, sr;
    div_t            stage_next;
    assign sl = div_step(div_pipe[k-1].rem_l, div_pipe[k-1].n_l,
                         div_pipe[k-1].r_low[QBITS-1]);
    assign sr = div_step(div_pipe[k-1].rem_r, div_pipe[k-1].n_r,
                         div_pipe[k-1].r_low[QBITS-1]);
    always_comb begin
      stage_next       = div_pipe[k-1];
      stage_next.rem_l = sl[NORM_W-1:0];
      stage_next.rem_r = sr[NORM_W-1:0];
      stage_next.q_l   = {div_pipe[k-1].q_l[QBITS-2:0], sl[NORM_W]};
      stage_next.q_r   = {div_pipe[k-1].q_r[QBITS-2:0], sr[NORM_W]};
      stage_next.r_low = {div_pipe[k-1].r_low[QBITS-2:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      div_pipe[k] <= stage_next;
    end
  end

  // square root: two quotient bits in, one root bit out per stage
  sq_t sq_pipe [DIST_W+1];
  logic [DIST_W:1] sq_v;

  always_comb begin
    sq_pipe[0].q_l    = div_pipe[QBITS].q_l;
    sq_pipe[0].q_r    = div_pipe[QBITS].q_r;
    sq_pipe[0].rem_l  = '0;
    sq_pipe[0].rem_r  = '0;
    sq_pipe[0].root_l = '0;
    sq_pipe[0].root_r = '0;
    sq_pipe[0].sat_l  = div_pipe[QBITS].sat_l;
    sq_pipe[0].sat_r  = div_pipe[QBITS].sat_r;
    sq_pipe[0].deg    = div_pipe[QBITS].deg;
  end

  for (genvar k = 1; k <= DIST_W; k++) begin : g_sqrt
    logic [DIST_W+SREM_W-1:0] tl, tr;
    sq_t                      stage_next;
    assign tl = sqrt_step(sq_pipe[k-1].rem_l, sq_pipe[k-1].root_l,
                          sq_pipe[k-1].q_l[QBITS-1:QBITS-2]);
    assign tr = sqrt_step(sq_pipe[k-1].rem_r, sq_pipe[k-1].root_r,
                          sq_pipe[k-1].q_r[QBITS-1:QBITS-2]);
    always_comb begin
      stage_next        = sq_pipe[k-1];
      stage_next.q_l    = {sq_pipe[k-1].q_l[QBITS-3:0], 2'b00};
      stage_next.q_r    = {sq_pipe[k-1].q_r[QBITS-3:0], 2'b00};
      stage_next.rem_l  = tl[SREM_W-1:0];
      stage_next.rem_r  = tr[SREM_W-1:0];
      stage_next.root_l = tl[DIST_W+SREM_W-1:SREM_W];
      stage_next.root_r = tr[DIST_W+SREM_W-1:SREM_W];
    end
    always_ff @(posedge clk) begin
      sq_pipe[k] <= stage_next;
    end
  end

  // output: clamp each distance, add, clamp the sum
  logic [DIST_W-1:0] d_l, d_r;
  logic [DIST_W:0]   d_sum;
  assign d_l   = sq_pipe[DIST_W].sat_l ? DIST_MAX : sq_pipe[DIST_W].root_l;
  assign d_r   = sq_pipe[DIST_W].sat_r ? DIST_MAX : sq_pipe[DIST_W].root_r;
  assign d_sum = {1'b0, d_l} + {1'b0, d_r};

  always_ff @(posedge clk) begin
    distance   <= (sq_pipe[DIST_W].deg || d_sum[DIST_W]) ? DIST_MAX : d_sum[DIST_W-1:0];
    degenerate <= sq_pipe[DIST_W].deg;
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      div_v <= '0;
      sq_v  <= '0;
      done  <= 1'b0;
    end else begin
      v     <= {v[5:1], start && !busy};
      div_v <= {div_v[QBITS-1:0], v[6]};
      sq_v  <= {sq_v[DIST_W-1:1], div_v[QBITS]};
      done  <= sq_v[DIST_W];
    end
  end

endmodule

FILE: tb/tb_symmetric_epipolar_distance.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_symmetric_epipolar_distance
// Drives point pairs into the epipolar distance pipeline under a series of
// fundamental matrices written over the APB port. Directed rows carry typed
// distances, the rest are computed exactly with wide integer arithmetic; the
// done beats are compared, in order, against that queue of expected distances.
// ---------------------------------------------------------------------------
module tb_symmetric_epipolar_distance;
  import sed_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PIPE_DRAIN  = 100;

  typedef struct {
    logic [PIX_W-1:0]  lx;
    logic [PIX_W-1:0]  ly;
    logic [PIX_W-1:0]  rx;
    logic [PIX_W-1:0]  ry;
    bit                typed;
    logic [DIST_W-1:0] dval;
    bit                deg;
  } pair_row_t;

  typedef struct {
    logic [DIST_W-1:0] dval;
    bit                deg;
  } dist_beat_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [PIX_W-1:0]  left_x;
  logic [PIX_W-1:0]  left_y;
  logic [PIX_W-1:0]  right_x;
  logic [PIX_W-1:0]  right_y;
  logic              done;
  logic [DIST_W-1:0] distance;
  logic              degenerate;

  // matrix copy held by the testbench
  logic [63:0] m_11_12, m_13_21, m_22_23, m_31_32, m_33;

  dist_beat_t pending_dist[$];
  int         n_errors;
  int         n_pairs;
  int         n_beats;
  int         n_degen;
  int         n_sat;
  int         stall_cnt;
  bit         quiet;

  symmetric_epipolar_distance dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .left_x(left_x), .left_y(left_y),
    .right_x(right_x), .right_y(right_y), .done(done), .distance(distance),
    .degenerate(degenerate)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // floor(sqrt(r2s / norm)) over 24 bits, zero norm flags a degenerate line
  function automatic logic [DIST_W-1:0] line_distance(input logic [255:0] r2s,
                                                      input longint a,
                                                      input longint b,
                                                      inout bit deg);
    logic [255:0]      aw, bw, norm, c;
    logic [DIST_W-1:0] q;
    aw = (a < 0) ? -a : a;
    bw = (b < 0) ? -b : b;
    norm = aw * aw + bw * bw;
    q = '0;
    if (norm == 0) begin
      deg = 1'b1;
      return DIST_MAX;
    end
    for (int k = DIST_W - 1; k >= 0; k--) begin
      c = q | (256'd1 << k);
      if (c * c * norm <= r2s) q = c[DIST_W-1:0];
    end
    return q;
  endfunction

  function automatic dist_beat_t epipolar_distance(input logic [PIX_W-1:0] lx,
                                                   input logic [PIX_W-1:0] ly,
                                                   input logic [PIX_W-1:0] rx,
                                                   input logic [PIX_W-1:0] ry);
    longint             xl, yl, xr, yr;
    longint             f11, f12, f13, f21, f22, f23, f31, f32, f33;
    longint             al, bl, cl, ar, br;
    logic signed [127:0] res;
    logic [255:0]       rw, r2s;
    logic [DIST_W:0]    total;
    dist_beat_t         o;
    bit                 deg;
    xl = lx; yl = ly; xr = rx; yr = ry;
    f11 = $signed(m_11_12[31:0]); f12 = $signed(m_11_12[63:32]);
    f13 = $signed(m_13_21[31:0]); f21 = $signed(m_13_21[63:32]);
    f22 = $signed(m_22_23[31:0]); f23 = $signed(m_22_23[63:32]);
    f31 = $signed(m_31_32[31:0]); f32 = $signed(m_31_32[63:32]);
    f33 = $signed(m_33[31:0]);
    al = f11 * xl + f12 * yl + f13;
    bl = f21 * xl + f22 * yl + f23;
    cl = f31 * xl + f32 * yl + f33;
    ar = f11 * xr + f21 * yr + f31;
    br = f12 * xr + f22 * yr + f32;
    res = 128'(signed'(al)) * 128'(signed'(xr)) + 128'(signed'(bl)) * 128'(signed'(yr))
        + 128'(signed'(cl));
    if (res < 0) res = -res;
    rw = res;
    r2s = (rw * rw) << (2 * DIST_FRAC_BITS);
    deg = 1'b0;
    total = line_distance(r2s, al, bl, deg);
    total = total + line_distance(r2s, ar, br, deg);
    o.deg = deg;
    o.dval = (deg || total > DIST_MAX) ? DIST_MAX : total[DIST_W-1:0];
    return o;
  endfunction

  // wait until every expected beat is back, then let the pipe settle
  task automatic drain_pipe();
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write with setup and access phases, mirrored into the matrix copy
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_F11_12: m_11_12 = val;
      REG_F13_21: m_13_21 = val;
      REG_F22_23: m_22_23 = val;
      REG_F31_32: m_31_32 = val;
      REG_F33:    m_33 = {32'd0, val[31:0]};
      default: ;
    endcase
  endtask

  task automatic load_matrix(input logic [31:0] c[9]);
    drain_pipe();
    write_reg(REG_F11_12, {c[1], c[0]});
    write_reg(REG_F13_21, {c[3], c[2]});
    write_reg(REG_F22_23, {c[4], c[5]} == 0 ? 64'd0 : {c[5], c[4]});
    write_reg(REG_F31_32, {c[7], c[6]});
    write_reg(REG_F33, {$urandom(), c[8]});
  endtask

  // hold one pair until accepted, push its expectation, then maybe idle
  task automatic send_pair(input pair_row_t row);
    bit        held;
    dist_beat_t e;
    start   <= 1'b1;
    left_x  <= row.lx;
    left_y  <= row.ly;
    right_x <= row.rx;
    right_y <= row.ry;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
    if (row.typed) begin
      e.dval = row.dval;
      e.deg  = row.deg;
    end else begin
      e = epipolar_distance(row.lx, row.ly, row.rx, row.ry);
    end
    pending_dist.push_back(e);
    n_pairs++;
    if (!quiet && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_row(input logic [PIX_W-1:0] lx, input logic [PIX_W-1:0] ly,
                          input logic [PIX_W-1:0] rx, input logic [PIX_W-1:0] ry);
    pair_row_t row;
    row = '{lx, ly, rx, ry, 1'b0, '0, 1'b0};
    send_pair(row);
  endtask

  task automatic idle_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] small_coef(input int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // check each done beat against the oldest expectation
  always @(posedge clk) begin
    dist_beat_t e;
    if (!rst && done) begin
      n_beats++;
      if (pending_dist.size() == 0) begin
        $error("done beat with nothing expected: distance %0h", distance);
        n_errors++;
      end else begin
        e = pending_dist.pop_front();
        if (e.deg) n_degen++;
        if (e.dval == DIST_MAX) n_sat++;
        if (distance !== e.dval) begin
          $error("distance: expected %0h, got %0h", e.dval, distance);
          n_errors++;
        end
        if (degenerate !== e.deg) begin
          $error("degenerate: expected %0b, got %0b", e.deg, degenerate);
          n_errors++;
        end
      end
    end
  end

  // end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("tb_symmetric_epipolar_distance failed");
        $finish;
      end
    end
  end

  // directed rows under the reset matrix: every pair degenerate
  pair_row_t zero_rows[4] = '{
    '{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 24'hFFFFFF, 1'b1},
    '{12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  1'b1, 24'hFFFFFF, 1'b1},
    '{12'hAAA,  12'h555,  12'h555,  12'hAAA,  1'b1, 24'hFFFFFF, 1'b1},
    '{12'd1,    12'd2,    12'd3,    12'd4,    1'b1, 24'hFFFFFF, 1'b1}
  };

  // rectified pair matrix: distance is twice the row offset, Q16.8
  pair_row_t stereo_rows[7] = '{
    '{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 24'd0,       1'b0},
    '{12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  1'b1, 24'd0,       1'b0},
    '{12'd0,    12'd0,    12'd0,    12'hFFF,  1'b1, 24'd2096640, 1'b0},
    '{12'hFFF,  12'd0,    12'd0,    12'hFFF,  1'b1, 24'd2096640, 1'b0},
    '{12'd100,  12'd10,   12'd3000, 12'd13,   1'b1, 24'd1536,    1'b0},
    '{12'd7,    12'd2000, 12'd9,    12'd1999, 1'b1, 24'd512,     1'b0},
    '{12'hFFF,  12'hFFF,  12'd0,    12'd0,    1'b1, 24'd2096640, 1'b0}
  };

  // corners for the extreme matrices, checked by the predictor
  pair_row_t corner_rows[4] = '{
    '{12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0, 1'b0},
    '{12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  1'b0, '0, 1'b0},
    '{12'hFFF,  12'd0,    12'd0,    12'hFFF,  1'b0, '0, 1'b0},
    '{12'd1,    12'hFFE,  12'h800,  12'd1,    1'b0, '0, 1'b0}
  };

  initial begin
    logic [31:0]      c[9];
    logic [PIX_W-1:0] lx, ly, rx, ry;
    int               sel;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; left_x = '0; left_y = '0; right_x = '0; right_y = '0;
    m_11_12 = '0; m_13_21 = '0; m_22_23 = '0; m_31_32 = '0; m_33 = '0;
    n_errors = 0; n_pairs = 0; n_beats = 0; n_degen = 0; n_sat = 0;
    stall_cnt = 0; quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset matrix, rectified pair, one-sided degeneracy, extremes
    foreach (zero_rows[i]) send_pair(zero_rows[i]);
    idle_start();
    c = '{0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 1, 0};
    load_matrix(c);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (stereo_rows[i]) send_pair(stereo_rows[i]);
    idle_start();
    c = '{0, 0, 1, 0, 0, 0, 0, 0, 0};
    load_matrix(c);
    send_row(12'd5, 12'd6, 12'd7, 12'd8);
    send_row(12'hFFF, 12'hFFF, 12'd0, 12'd0);
    idle_start();
    c = '{default: 32'h7FFFFFFF};
    load_matrix(c);
    foreach (corner_rows[i]) send_pair(corner_rows[i]);
    idle_start();
    c = '{default: 32'h80000000};
    load_matrix(c);
    foreach (corner_rows[i]) send_pair(corner_rows[i]);
    idle_start();

    // random phases, one matrix each
    for (int ph = 0; ph < 10; ph++) begin
      sel = ph % 5;
      case (sel)
        0: begin
          // scaled rectified-style matrix with small perturbation
          foreach (c[k]) c[k] = small_coef(1);
          c[5] = small_coef(1) - 32'(200 * (ph + 1));
          c[7] = 32'(200 * (ph + 1)) + small_coef(1);
        end
        1: foreach (c[k]) c[k] = small_coef(16);
        2: foreach (c[k]) c[k] = ($urandom_range(2) == 0) ? 32'd0 : small_coef(3);
        3: foreach (c[k]) c[k] = $urandom();
        default: foreach (c[k]) c[k] = small_coef(1 << $urandom_range(4, 20));
      endcase
      load_matrix(c);
      for (int n = 0; n < 105; n++) begin
        quiet = (ph == 4);
        lx = $urandom();
        ly = $urandom();
        if (sel == 0 && $urandom_range(9) < 8) begin
          // near-matching pair along the same row
          rx = $urandom();
          ry = ly + 12'($signed($urandom_range(8)) - 4);
        end else begin
          rx = $urandom();
          ry = $urandom();
        end
        send_row(lx, ly, rx, ry);
        if (ph == 2 && n == 50) begin
          idle_start();
          drain_pipe();
        end
      end
      quiet = 1'b0;
      idle_start();
    end

    drain_pipe();
    repeat (PIPE_DRAIN) @(posedge clk);
    $display("covered %0d pairs over 15 matrices, %0d beats checked", n_pairs, n_beats);
    $display("%0d degenerate and %0d saturated expectations", n_degen, n_sat);
    if (n_errors == 0 && pending_dist.size() == 0) begin
      $display("tb_symmetric_epipolar_distance passed");
    end else begin
      $display("tb_symmetric_epipolar_distance failed");
    end
    $finish;
  end

endmodule
